// ===== hdl/hslrgb_pkg.sv =====
// Shared types and constants for the HSL to RGB percent converter.
// Depends on nothing; every other file in hdl refers to it by scoped names.
`default_nettype none

package hslrgb_pkg;

   // One input beat: hue in degrees, saturation and lightness in percent.
   typedef struct packed {
      logic [9:0] hue_deg;
      logic [6:0] sat_pct;
      logic [6:0] light_pct;
   } req_type;

   // One result beat: 8-bit red, green and blue.
   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
   } rsp_type;

   // Levels and per-channel hues passed from the front stage to the channel lanes.
   typedef struct packed {
      logic [8:0]  red_hue;
      logic [8:0]  green_hue;
      logic [8:0]  blue_hue;
      logic [13:0] level_hi;
      logic [13:0] level_lo;
   } lvl_type;

   localparam int unsigned PIPE_DEPTH = 5;

   localparam logic [9:0]  HUE_TURN      = 10'd360;
   localparam logic [9:0]  HUE_TWO_TURNS = 10'd720;
   localparam logic [8:0]  HUE_SIXTH     = 9'd60;
   localparam logic [8:0]  HUE_THIRD     = 9'd120;
   localparam logic [8:0]  HUE_HALF      = 9'd180;
   localparam logic [8:0]  HUE_TWO_THIRD = 9'd240;
   localparam logic [6:0]  PCT_FULL      = 7'd100;
   localparam logic [6:0]  PCT_HALF      = 7'd50;
   localparam logic [14:0] PCT_DOUBLE    = 15'd200;
   localparam logic [5:0]  RAMP_FULL     = 6'd60;

   // 255/600000 reduces to 17/40000 = 17 / (64 * 625). The divide by 625 is a
   // multiply by ceil(2^27/625); the error term stays below one for all ramps.
   localparam logic [23:0] SCALE_NUM     = 24'd17;
   localparam logic [35:0] RECIP_625     = 36'd214749;

endpackage

`default_nettype wire

// ===== hdl/hslrgb_levels.sv =====
// Front stage: hue reduction, percentage clamps, high and low levels, channel hues.
// Depends on hslrgb_pkg.
`default_nettype none

module hslrgb_levels (
   input  wire logic              clock,
   input  wire hslrgb_pkg::req_type req_data,
   output hslrgb_pkg::lvl_type    lvl_ff
);

   hslrgb_pkg::lvl_type lvl_in;
   logic [6:0]  sat_c;
   logic [6:0]  light_c;
   logic [9:0]  hue_w;
   logic [8:0]  hue_m;
   logic [14:0] prod_dark;
   logic [14:0] prod_bright;
   logic [13:0] level_hi;
   logic [14:0] light_x2;

   always_comb begin
      sat_c   = (req_data.sat_pct > hslrgb_pkg::PCT_FULL) ? hslrgb_pkg::PCT_FULL
                                                          : req_data.sat_pct;
      light_c = (req_data.light_pct > hslrgb_pkg::PCT_FULL) ? hslrgb_pkg::PCT_FULL
                                                            : req_data.light_pct;

      // Inputs never reach three turns, so two conditional subtractions suffice.
      if (req_data.hue_deg >= hslrgb_pkg::HUE_TWO_TURNS) begin
         hue_w = req_data.hue_deg - hslrgb_pkg::HUE_TWO_TURNS;
      end else if (req_data.hue_deg >= hslrgb_pkg::HUE_TURN) begin
         hue_w = req_data.hue_deg - hslrgb_pkg::HUE_TURN;
      end else begin
         hue_w = req_data.hue_deg;
      end
      hue_m = hue_w[8:0];

      prod_dark   = 15'(light_c) * (15'(sat_c) + 15'(hslrgb_pkg::PCT_FULL));
      prod_bright = (15'(light_c) + 15'(sat_c)) * 15'(hslrgb_pkg::PCT_FULL)
                    - 15'(sat_c) * 15'(light_c);
      level_hi    = (light_c < hslrgb_pkg::PCT_HALF) ? prod_dark[13:0] : prod_bright[13:0];
      light_x2    = 15'(light_c) * hslrgb_pkg::PCT_DOUBLE - {1'b0, level_hi};

      lvl_in.level_hi  = level_hi;
      lvl_in.level_lo  = light_x2[13:0];
      lvl_in.green_hue = hue_m;
      lvl_in.red_hue   = (hue_m < hslrgb_pkg::HUE_TWO_THIRD) ? hue_m + hslrgb_pkg::HUE_THIRD
                                                             : hue_m - hslrgb_pkg::HUE_TWO_THIRD;
      lvl_in.blue_hue  = (hue_m >= hslrgb_pkg::HUE_THIRD) ? hue_m - hslrgb_pkg::HUE_THIRD
                                                          : hue_m + hslrgb_pkg::HUE_TWO_THIRD;
   end

   always_ff @(posedge clock) begin
      lvl_ff <= lvl_in;
   end

endmodule

`default_nettype wire

// ===== hdl/hslrgb_ramp.sv =====
// One channel's piecewise-linear hue ramp, two register stages.
// Depends on hslrgb_pkg.
`default_nettype none

module hslrgb_ramp (
   input  wire logic        clock,
   input  wire logic [8:0]  hue,
   input  wire logic [13:0] level_hi,
   input  wire logic [13:0] level_lo,
   output logic      [19:0] ramp_ff
);

   logic [5:0]  weight_in, weight_ff;
   logic [13:0] diff_in, diff_ff;
   logic [19:0] base_in, base_ff;
   logic [19:0] ramp_in;
   logic [8:0]  fall;

   // The ramp is lo*60 + (hi - lo)*weight, with the weight running 0..60.
   always_comb begin
      fall = hslrgb_pkg::HUE_TWO_THIRD - hue;
      if (hue < hslrgb_pkg::HUE_SIXTH) begin
         weight_in = hue[5:0];
      end else if (hue < hslrgb_pkg::HUE_HALF) begin
         weight_in = hslrgb_pkg::RAMP_FULL;
      end else if (hue < hslrgb_pkg::HUE_TWO_THIRD) begin
         weight_in = fall[5:0];
      end else begin
         weight_in = 6'd0;
      end
      diff_in = level_hi - level_lo;
      base_in = 20'(level_lo) * 20'(hslrgb_pkg::RAMP_FULL);
      ramp_in = base_ff + 20'(diff_ff) * 20'(weight_ff);
   end

   always_ff @(posedge clock) begin
      weight_ff <= weight_in;
      diff_ff   <= diff_in;
      base_ff   <= base_in;
      ramp_ff   <= ramp_in;
   end

endmodule

`default_nettype wire

// ===== hdl/hslrgb_scale.sv =====
// Scales one ramp value by 255/600000 with truncation, two register stages.
// Depends on hslrgb_pkg.
`default_nettype none

module hslrgb_scale (
   input  wire logic        clock,
   input  wire logic [19:0] ramp,
   output logic      [7:0]  level_ff
);

   logic [23:0] num;
   logic [17:0] quot64_in, quot64_ff;
   logic [35:0] prod;
   logic [7:0]  level_in;

   always_comb begin
      num       = 24'(ramp) * hslrgb_pkg::SCALE_NUM;
      quot64_in = num[23:6];
      prod      = 36'(quot64_ff) * hslrgb_pkg::RECIP_625;
      level_in  = prod[34:27];
   end

   always_ff @(posedge clock) begin
      quot64_ff <= quot64_in;
      level_ff  <= level_in;
   end

endmodule

`default_nettype wire

// ===== hdl/hsl_to_rgb_percent_top.sv =====
// Top level of the HSL to RGB percent converter: handshake, valid line, channel lanes.
// Depends on hslrgb_pkg, hslrgb_levels, hslrgb_ramp and hslrgb_scale.
`default_nettype none

// Channel   Ports                       Beat taken when
// -------   -------------------------   ------------------------------
// request   start, busy, req_data       start high and busy low at a clock edge
// result    rsp_valid, rsp_data         rsp_valid high; held for one cycle only
//
// The converter is a five-stage pipeline and takes one beat in every cycle;
// busy is therefore always low. A request beat passes the stages in order;
// levels, ramp weight, ramp multiply, scale by 17/64, and the reciprocal
// multiply for the divide by 625 each own one stage.
// Reset clears only the valid line; the data registers carry whatever they hold.
// The receiver cannot hold results off, so nothing in the pipeline ever stalls.

module hsl_to_rgb_percent_top (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire hslrgb_pkg::req_type req_data,
   output logic                     rsp_valid,
   output hslrgb_pkg::rsp_type      rsp_data
);

   logic                               accept;
   logic [hslrgb_pkg::PIPE_DEPTH-1:0]  valid_in, valid_ff;
   hslrgb_pkg::lvl_type                lvl;
   logic [19:0]                        red_ramp, green_ramp, blue_ramp;

   // Every stage advances in every cycle, so no beat is ever refused.
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // The valid line runs alongside the data stages, one bit per stage.
   assign valid_in = {valid_ff[hslrgb_pkg::PIPE_DEPTH-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff[hslrgb_pkg::PIPE_DEPTH-1];

   // Stage one: clamps, hue reduction and the two levels shared by all channels.
   // Zero saturation needs no special path: both levels equal 100*lightness,
   // giving the grey value lightness*255/100 on every channel.
   hslrgb_levels u_levels (
      .clock    (clock),
      .req_data (req_data),
      .lvl_ff   (lvl)
   );

   // Stages two and three: one hue ramp per channel.
   hslrgb_ramp u_ramp_red (
      .clock    (clock),
      .hue      (lvl.red_hue),
      .level_hi (lvl.level_hi),
      .level_lo (lvl.level_lo),
      .ramp_ff  (red_ramp)
   );

   hslrgb_ramp u_ramp_green (
      .clock    (clock),
      .hue      (lvl.green_hue),
      .level_hi (lvl.level_hi),
      .level_lo (lvl.level_lo),
      .ramp_ff  (green_ramp)
   );

   hslrgb_ramp u_ramp_blue (
      .clock    (clock),
      .hue      (lvl.blue_hue),
      .level_hi (lvl.level_hi),
      .level_lo (lvl.level_lo),
      .ramp_ff  (blue_ramp)
   );

   // Stages four and five: scaling to eight bits; the last register drives the port.
   hslrgb_scale u_scale_red (
      .clock    (clock),
      .ramp     (red_ramp),
      .level_ff (rsp_data.red_out)
   );

   hslrgb_scale u_scale_green (
      .clock    (clock),
      .ramp     (green_ramp),
      .level_ff (rsp_data.green_out)
   );

   hslrgb_scale u_scale_blue (
      .clock    (clock),
      .ramp     (blue_ramp),
      .level_ff (rsp_data.blue_out)
   );

endmodule

`default_nettype wire
